// ----- src/mpq_pkg.sv -----
// Shared types and codes for the min priority queue.
`default_nettype none

package mpq_pkg;

   localparam int TagWidth = 16;
   localparam int PriorityWidth = 16;

   localparam logic CMD_ENQUEUE = 1'b0;
   localparam logic CMD_DEQUEUE = 1'b1;

   typedef enum logic [1:0] {
      STATUS_ADDED = 2'd0,
      STATUS_TAKEN = 2'd1,
      STATUS_EMPTY = 2'd2,
      STATUS_FULL  = 2'd3
   } status_type;

   typedef struct packed {
      logic                            command;
      logic [TagWidth-1:0]             task_tag;
      logic signed [PriorityWidth-1:0] task_priority;
   } req_type;

   typedef struct packed {
      status_type                      status;
      logic [TagWidth-1:0]             out_tag;
      logic signed [PriorityWidth-1:0] out_priority;
   } rsp_type;

   typedef struct packed {
      logic [TagWidth-1:0]             tag;
      logic signed [PriorityWidth-1:0] priority_value;
   } entry_type;

   typedef struct packed {
      logic      insert;
      logic      remove;
      entry_type entry;
   } cell_ctrl_type;

endpackage

`default_nettype wire

// ----- src/min_priority_queue.sv -----
// Min priority queue: a sorted chain of cells, the head always the next to leave.
// The status transfer is registered and appears on rsp_data in the cycle after start is taken.
// Throughput: one command per cycle; every cell compares against the new entry
// and shifts in the same cycle, so busy stays low.
// Reset empties the chain by clearing each cell's valid flag; slot data is not cleared.
// The receiver cannot stall: rsp_strobe marks each result for one cycle.
`default_nettype none

module min_priority_queue
   import mpq_pkg::*;
#(
   parameter int DEPTH = 64
)
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   output logic      busy,
   input  req_type   req_data,
   output logic      rsp_strobe,
   output rsp_type   rsp_data
);

   entry_type     cell_entry [DEPTH];
   logic          cell_valid [DEPTH];
   logic          cell_gt    [DEPTH];
   cell_ctrl_type ctrl;
   logic          full;
   logic          empty;
   logic          accept;

   logic    rsp_strobe_ff, rsp_strobe_in;
   rsp_type rsp_ff, rsp_in;

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign full   = cell_valid[DEPTH-1];
   assign empty  = !cell_valid[0];

   always_comb begin
      ctrl.entry.tag            = req_data.task_tag;
      ctrl.entry.priority_value = req_data.task_priority;
      ctrl.insert = accept && (req_data.command == CMD_ENQUEUE) && !full;
      ctrl.remove = accept && (req_data.command == CMD_DEQUEUE) && !empty;
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      entry_type left_entry;
      logic      left_valid;
      logic      left_gt;
      entry_type right_entry;
      logic      right_valid;

      if (i == 0) begin : g_head
         assign left_entry  = '0;
         assign left_valid  = 1'b0;
         assign left_gt     = 1'b0;
      end else begin : g_body
         assign left_entry  = cell_entry[i-1];
         assign left_valid  = cell_valid[i-1];
         assign left_gt     = cell_gt[i-1];
      end

      if (i == DEPTH-1) begin : g_tail
         assign right_entry = '0;
         assign right_valid = 1'b0;
      end else begin : g_mid
         assign right_entry = cell_entry[i+1];
         assign right_valid = cell_valid[i+1];
      end

      mpq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .left_entry  (left_entry),
         .left_valid  (left_valid),
         .left_gt     (left_gt),
         .right_entry (right_entry),
         .right_valid (right_valid),
         .entry       (cell_entry[i]),
         .valid       (cell_valid[i]),
         .gt          (cell_gt[i])
      );
   end

   always_comb begin
      rsp_strobe_in = accept;
      rsp_in        = '0;
      if (req_data.command == CMD_ENQUEUE) begin
         rsp_in.status = full ? STATUS_FULL : STATUS_ADDED;
      end else if (empty) begin
         rsp_in.status = STATUS_EMPTY;
      end else begin
         // Head of the chain holds the smallest, earliest entry.
         rsp_in.status       = STATUS_TAKEN;
         rsp_in.out_tag      = cell_entry[0].tag;
         rsp_in.out_priority = cell_entry[0].priority_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= rsp_strobe_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

`default_nettype wire

// ----- src/mpq_cell.sv -----
// One slot of the sorted chain: holds an entry and shifts with its neighbors.
`default_nettype none

module mpq_cell
   import mpq_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  cell_ctrl_type      ctrl,
   input  entry_type          left_entry,
   input  wire logic          left_valid,
   input  wire logic          left_gt,
   input  entry_type          right_entry,
   input  wire logic          right_valid,
   output entry_type          entry,
   output logic               valid,
   output logic               gt
);

   entry_type entry_ff, entry_in;
   logic      valid_ff, valid_in;

   // Empty slots count as larger than any new entry; equal keys stay ahead.
   assign gt = !valid_ff ||
               ($signed(entry_ff.priority_value) > $signed(ctrl.entry.priority_value));

   always_comb begin
      entry_in = entry_ff;
      valid_in = valid_ff;
      if (ctrl.insert && gt) begin
         if (left_gt) begin
            entry_in = left_entry;
            valid_in = left_valid;
         end else begin
            entry_in = ctrl.entry;
            valid_in = 1'b1;
         end
      end else if (ctrl.remove) begin
         entry_in = right_entry;
         valid_in = right_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;
   assign valid = valid_ff;

endmodule

`default_nettype wire
